>>> src/gsd_pkg.sv
// ----------------------------------------------------------------------------
// gsd_pkg: shared types and constants of the GPS stuck detector
// Status and reason codes, item kinds, register indexes, queue entry layout.
// ----------------------------------------------------------------------------
package gsd_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam int IN_DATA_W  = 200;
  localparam int OUT_DATA_W = 112;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_CLEAR  = 2'd1,
    KIND_ENABLE = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_INITIAL    = 3'd0,
    ST_DISABLED   = 3'd1,
    ST_WAITING    = 3'd2,
    ST_POOR       = 3'd3,
    ST_MONITORING = 3'd4,
    ST_STUCK      = 3'd5
  } mon_state_t;

  typedef enum logic [3:0] {
    RS_NONE       = 4'd0,
    RS_DISABLED   = 4'd1,
    RS_INVALID    = 4'd2,
    RS_STALE      = 4'd3,
    RS_BAD_SPEED  = 4'd4,
    RS_POOR       = 4'd5,
    RS_MONITORING = 4'd6,
    RS_MOVING     = 4'd7,
    RS_TIMEOUT    = 4'd8,
    RS_CLEARED    = 4'd9
  } reason_t;

  typedef enum logic [2:0] {
    CFG_MIN_FIX_GRADE     = 3'd0,
    CFG_MIN_SATELLITES    = 3'd1,
    CFG_MAX_HDOP_CENTI    = 3'd2,
    CFG_MAX_PDOP_CENTI    = 3'd3,
    CFG_MOVING_SPEED_MM_S = 3'd4,
    CFG_CONFIRM_SAMPLES   = 3'd5,
    CFG_STUCK_TIMEOUT_MS  = 3'd6,
    CFG_STALE_TIMEOUT_MS  = 3'd7
  } cfg_idx_t;

  localparam logic [3:0]  RST_MIN_FIX_GRADE     = 4'd1;
  localparam logic [5:0]  RST_MIN_SATELLITES    = 6'd4;
  localparam logic [13:0] RST_MAX_HDOP_CENTI    = 14'd500;
  localparam logic [13:0] RST_MAX_PDOP_CENTI    = 14'd600;
  localparam logic [14:0] RST_MOVING_SPEED_MM_S = 15'd50;
  localparam logic [7:0]  RST_CONFIRM_SAMPLES   = 8'd3;
  localparam logic [31:0] RST_STUCK_TIMEOUT_MS  = 32'd30000;
  localparam logic [31:0] RST_STALE_TIMEOUT_MS  = 32'd3000;

  typedef struct packed {
    logic [3:0]  min_fix_grade;
    logic [5:0]  min_satellites;
    logic [13:0] max_hdop_centi;
    logic [13:0] max_pdop_centi;
    logic [14:0] moving_speed_mm_s;
    logic [7:0]  confirm_samples;
    logic [31:0] stuck_timeout_ms;
    logic [31:0] stale_timeout_ms;
  } cfg_t;

  // classified request as it sits in the queue
  typedef struct packed {
    kind_t              kind;
    logic [31:0]        now_ms;
    logic [47:0]        utc_ms;
    logic               enable;
    logic signed [15:0] speed_mm_s;
    logic [13:0]        hdop_centi;
    logic [13:0]        pdop_centi;
    logic [5:0]         satellites;
    logic [3:0]         fix_grade;
    logic               basic_ok;
    logic               speed_neg;
    logic               quality_ok;
    logic               moving;
  } item_t;

endpackage

>>> src/gps_stuck_detector.sv
// ----------------------------------------------------------------------------
// gps_stuck_detector: flags a robot as stuck from a stream of GPS fixes
// A request waits in the queue, and its result is loaded into the output register that drives m_tvalid.
// Throughput: one request per cycle while the queue has room and the result side is not stalled.
// The request queue absorbs output stalls; s_tready drops only when it fills.
// Reset (rst, synchronous) empties the queue and output register, restores
// register defaults, enables monitoring and sets the status to initial.
// ----------------------------------------------------------------------------
module gps_stuck_detector #(
  parameter int QUEUE_DEPTH = gsd_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  // kind [1:0]
  input  logic [1:0]                     s_tuser,
  // now_ms, fix_valid, utc_ms, latitude_e7, longitude_e7, fix grade,
  // satellites, speed_mm_s, hdop_centi, pdop_centi, enable
  input  logic [gsd_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // monitor_state, stuck_flag, reason_code, last_speed_mm_s, last_hdop_centi,
  // last_pdop_centi, last_satellites, last fix grade, last_accepted_utc_ms
  output logic [gsd_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic                           cfg_we,
  input  logic [gsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gsd_pkg::CFG_DATA_W-1:0] cfg_data
);

  gsd_pkg::cfg_t  cfg;
  gsd_pkg::item_t front_item;
  gsd_pkg::item_t head_item;
  logic           q_full;
  logic           q_valid;
  logic           q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_fix_grade     <= gsd_pkg::RST_MIN_FIX_GRADE;
      cfg.min_satellites    <= gsd_pkg::RST_MIN_SATELLITES;
      cfg.max_hdop_centi    <= gsd_pkg::RST_MAX_HDOP_CENTI;
      cfg.max_pdop_centi    <= gsd_pkg::RST_MAX_PDOP_CENTI;
      cfg.moving_speed_mm_s <= gsd_pkg::RST_MOVING_SPEED_MM_S;
      cfg.confirm_samples   <= gsd_pkg::RST_CONFIRM_SAMPLES;
      cfg.stuck_timeout_ms  <= gsd_pkg::RST_STUCK_TIMEOUT_MS;
      cfg.stale_timeout_ms  <= gsd_pkg::RST_STALE_TIMEOUT_MS;
    end else if (cfg_we) begin
      unique case (gsd_pkg::cfg_idx_t'(cfg_index))
        gsd_pkg::CFG_MIN_FIX_GRADE:     cfg.min_fix_grade     <= cfg_data[3:0];
        gsd_pkg::CFG_MIN_SATELLITES:    cfg.min_satellites    <= cfg_data[5:0];
        gsd_pkg::CFG_MAX_HDOP_CENTI:    cfg.max_hdop_centi    <= cfg_data[13:0];
        gsd_pkg::CFG_MAX_PDOP_CENTI:    cfg.max_pdop_centi    <= cfg_data[13:0];
        gsd_pkg::CFG_MOVING_SPEED_MM_S: cfg.moving_speed_mm_s <= cfg_data[14:0];
        gsd_pkg::CFG_CONFIRM_SAMPLES:   cfg.confirm_samples   <= cfg_data[7:0];
        gsd_pkg::CFG_STUCK_TIMEOUT_MS:  cfg.stuck_timeout_ms  <= cfg_data;
        gsd_pkg::CFG_STALE_TIMEOUT_MS:  cfg.stale_timeout_ms  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign s_tready = !q_full;

  gsd_front u_front (
    .kind (s_tuser),
    .data (s_tdata),
    .cfg  (cfg),
    .item (front_item)
  );

  gsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head_item (head_item)
  );

  gsd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (head_item),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

>>> src/gsd_front.sv
// ----------------------------------------------------------------------------
// gsd_front: request unpack and classification
// Splits the input stream word into fields and evaluates the checks that
// depend on the request and configuration only.
// ----------------------------------------------------------------------------
module gsd_front (
  input  logic [1:0]                     kind,
  input  logic [gsd_pkg::IN_DATA_W-1:0]  data,
  input  gsd_pkg::cfg_t                  cfg,
  output gsd_pkg::item_t                 item
);

  logic signed [30:0] latitude_e7;
  logic signed [31:0] longitude_e7;
  logic               fix_valid;

  assign fix_valid    = data[32];
  assign latitude_e7  = data[111:81];
  assign longitude_e7 = data[143:112];

  always_comb begin
    item.kind        = gsd_pkg::kind_t'(kind);
    item.now_ms      = data[31:0];
    item.utc_ms      = data[80:33];
    item.fix_grade   = data[147:144];
    item.satellites  = data[153:148];
    item.speed_mm_s  = data[169:154];
    item.hdop_centi  = data[183:170];
    item.pdop_centi  = data[197:184];
    item.enable      = data[198];

    item.basic_ok = fix_valid && (item.utc_ms != 48'd0) && (latitude_e7 != 31'sd0) &&
                    (longitude_e7 != 32'sd0) && (item.fix_grade >= cfg.min_fix_grade);
    item.speed_neg = item.speed_mm_s[15];
    item.quality_ok = !((item.satellites < cfg.min_satellites) ||
                        (item.hdop_centi == 14'd0) ||
                        (item.hdop_centi > cfg.max_hdop_centi) ||
                        ((item.pdop_centi != 14'd0) && (item.pdop_centi > cfg.max_pdop_centi)));
    item.moving = !item.speed_mm_s[15] && (item.speed_mm_s[14:0] >= cfg.moving_speed_mm_s);
  end

endmodule

>>> src/gsd_queue.sv
// ----------------------------------------------------------------------------
// gsd_queue: short request queue between front and back
// Register-based FIFO of classified requests; head is read directly.
// ----------------------------------------------------------------------------
module gsd_queue #(
  parameter int DEPTH = gsd_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  gsd_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output gsd_pkg::item_t head_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  gsd_pkg::item_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> src/gsd_back.sv
// ----------------------------------------------------------------------------
// gsd_back: tracking state and status update
// Applies one queued request per cycle, unless the output register is held, to the detector state and loads the
// resulting status into the output register.
// ----------------------------------------------------------------------------
module gsd_back (
  input  logic                           clk,
  input  logic                           rst,
  input  gsd_pkg::cfg_t                  cfg,
  input  logic                           q_valid,
  input  gsd_pkg::item_t                 q_item,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [gsd_pkg::OUT_DATA_W-1:0] out_data
);

  logic        monitoring_on, monitoring_on_next;
  logic        have_sample, have_sample_next;
  logic [47:0] sample_utc, sample_utc_next;
  logic [31:0] sample_seen_at, sample_seen_at_next;
  logic        tracking, tracking_next;
  logic [7:0]  fast_count, fast_count_next;
  logic [31:0] motion_seen_at, motion_seen_at_next;

  gsd_pkg::mon_state_t st_state, st_state_next;
  logic                st_stuck, st_stuck_next;
  gsd_pkg::reason_t    st_reason, st_reason_next;
  logic signed [15:0]  st_speed, st_speed_next;
  logic [13:0]         st_hdop, st_hdop_next;
  logic [13:0]         st_pdop, st_pdop_next;
  logic [5:0]          st_sats, st_sats_next;
  logic [3:0]          st_fixq, st_fixq_next;
  logic [47:0]         st_utc, st_utc_next;

  logic [31:0] stale_age;
  logic [31:0] motion_age;
  logic [7:0]  fast_inc;

  assign q_pop      = q_valid && (!out_valid || out_ready);
  assign stale_age  = q_item.now_ms - sample_seen_at;
  assign motion_age = q_item.now_ms - motion_seen_at;

  always_comb begin
    monitoring_on_next  = monitoring_on;
    have_sample_next    = have_sample;
    sample_utc_next     = sample_utc;
    sample_seen_at_next = sample_seen_at;
    tracking_next       = tracking;
    fast_count_next     = fast_count;
    motion_seen_at_next = motion_seen_at;
    st_state_next       = st_state;
    st_stuck_next       = st_stuck;
    st_reason_next      = st_reason;
    st_speed_next       = st_speed;
    st_hdop_next        = st_hdop;
    st_pdop_next        = st_pdop;
    st_sats_next        = st_sats;
    st_fixq_next        = st_fixq;
    st_utc_next         = st_utc;
    fast_inc            = '0;

    unique case (q_item.kind)
      gsd_pkg::KIND_SAMPLE: begin
        if (!monitoring_on) begin
          st_state_next  = gsd_pkg::ST_DISABLED;
          st_stuck_next  = 1'b0;
          st_reason_next = gsd_pkg::RS_DISABLED;
        end else begin
          st_speed_next = q_item.speed_mm_s;
          st_hdop_next  = q_item.hdop_centi;
          st_pdop_next  = q_item.pdop_centi;
          st_sats_next  = q_item.satellites;
          st_fixq_next  = q_item.fix_grade;
          if (!q_item.basic_ok) begin
            tracking_next       = 1'b0;
            fast_count_next     = '0;
            motion_seen_at_next = '0;
            st_state_next       = gsd_pkg::ST_WAITING;
            st_stuck_next       = 1'b0;
            st_reason_next      = gsd_pkg::RS_INVALID;
          end else if (have_sample && (q_item.utc_ms == sample_utc)) begin
            // repeated timestamp: state and reason hold until the stale time runs out
            if (stale_age > cfg.stale_timeout_ms) begin
              tracking_next       = 1'b0;
              fast_count_next     = '0;
              motion_seen_at_next = '0;
              st_state_next       = gsd_pkg::ST_WAITING;
              st_stuck_next       = 1'b0;
              st_reason_next      = gsd_pkg::RS_STALE;
            end
          end else if (q_item.speed_neg) begin
            tracking_next       = 1'b0;
            fast_count_next     = '0;
            motion_seen_at_next = '0;
            st_state_next       = gsd_pkg::ST_WAITING;
            st_stuck_next       = 1'b0;
            st_reason_next      = gsd_pkg::RS_BAD_SPEED;
          end else begin
            have_sample_next    = 1'b1;
            sample_utc_next     = q_item.utc_ms;
            sample_seen_at_next = q_item.now_ms;
            st_utc_next         = q_item.utc_ms;
            if (!q_item.quality_ok) begin
              tracking_next       = 1'b0;
              fast_count_next     = '0;
              motion_seen_at_next = '0;
              st_state_next       = gsd_pkg::ST_POOR;
              st_stuck_next       = 1'b0;
              st_reason_next      = gsd_pkg::RS_POOR;
            end else if (!tracking) begin
              tracking_next       = 1'b1;
              motion_seen_at_next = q_item.now_ms;
              fast_count_next     = {7'd0, q_item.moving};
              st_state_next       = gsd_pkg::ST_MONITORING;
              st_stuck_next       = 1'b0;
              st_reason_next      = gsd_pkg::RS_MONITORING;
            end else begin
              // saturate at the counter's top
              if (q_item.moving) begin
                fast_inc = (fast_count == 8'hFF) ? fast_count : fast_count + 8'd1;
              end
              fast_count_next = fast_inc;
              if (fast_inc >= cfg.confirm_samples) begin
                motion_seen_at_next = q_item.now_ms;
                st_state_next       = gsd_pkg::ST_MONITORING;
                st_stuck_next       = 1'b0;
                st_reason_next      = gsd_pkg::RS_MOVING;
              end else if (motion_age >= cfg.stuck_timeout_ms) begin
                st_state_next  = gsd_pkg::ST_STUCK;
                st_stuck_next  = 1'b1;
                st_reason_next = gsd_pkg::RS_TIMEOUT;
              end else begin
                st_state_next  = gsd_pkg::ST_MONITORING;
                st_stuck_next  = 1'b0;
                st_reason_next = gsd_pkg::RS_MONITORING;
              end
            end
          end
        end
      end
      gsd_pkg::KIND_CLEAR: begin
        if (st_state == gsd_pkg::ST_STUCK) begin
          motion_seen_at_next = q_item.now_ms;
          st_state_next       = gsd_pkg::ST_MONITORING;
          st_reason_next      = gsd_pkg::RS_CLEARED;
        end
        st_stuck_next = 1'b0;
      end
      gsd_pkg::KIND_ENABLE: begin
        monitoring_on_next = q_item.enable;
        if (!q_item.enable) begin
          tracking_next       = 1'b0;
          fast_count_next     = '0;
          motion_seen_at_next = '0;
          st_state_next       = gsd_pkg::ST_DISABLED;
          st_stuck_next       = 1'b0;
          st_reason_next      = gsd_pkg::RS_DISABLED;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      monitoring_on  <= 1'b1;
      have_sample    <= 1'b0;
      sample_utc     <= '0;
      sample_seen_at <= '0;
      tracking       <= 1'b0;
      fast_count     <= '0;
      motion_seen_at <= '0;
      st_state       <= gsd_pkg::ST_INITIAL;
      st_stuck       <= 1'b0;
      st_reason      <= gsd_pkg::RS_NONE;
      st_speed       <= '0;
      st_hdop        <= '0;
      st_pdop        <= '0;
      st_sats        <= '0;
      st_fixq        <= '0;
      st_utc         <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (q_pop) begin
        monitoring_on  <= monitoring_on_next;
        have_sample    <= have_sample_next;
        sample_utc     <= sample_utc_next;
        sample_seen_at <= sample_seen_at_next;
        tracking       <= tracking_next;
        fast_count     <= fast_count_next;
        motion_seen_at <= motion_seen_at_next;
        st_state       <= st_state_next;
        st_stuck       <= st_stuck_next;
        st_reason      <= st_reason_next;
        st_speed       <= st_speed_next;
        st_hdop        <= st_hdop_next;
        st_pdop        <= st_pdop_next;
        st_sats        <= st_sats_next;
        st_fixq        <= st_fixq_next;
        st_utc         <= st_utc_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data <= {2'b00, st_utc_next, st_fixq_next, st_sats_next, st_pdop_next,
                   st_hdop_next, st_speed_next, st_reason_next, st_stuck_next,
                   st_state_next};
    end
  end

endmodule

>>> tb/gsd_status_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gsd_status_checker: prediction and compare for the GPS stuck detector
// Watches the request, result and register-write ports, keeps its own copy
// of the detector state and configuration, and checks each result in order.
// ----------------------------------------------------------------------------
module gsd_status_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [1:0]                     s_tuser,
  input  logic [gsd_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [gsd_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic                           cfg_we,
  input  logic [gsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gsd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             errors,
  output int                             pending
);
  import gsd_pkg::*;

  // request layout, lowest field last
  typedef struct packed {
    logic               pad;
    logic               enable;
    logic [13:0]        pdop;
    logic [13:0]        hdop;
    logic signed [15:0] speed;
    logic [5:0]         sats;
    logic [3:0]         fixq;
    logic signed [31:0] lon;
    logic signed [30:0] lat;
    logic [47:0]        utc;
    logic               valid;
    logic [31:0]        now;
  } fix_req_t;

  typedef struct packed {
    logic [1:0]         pad;
    logic [47:0]        utc;
    logic [3:0]         fixq;
    logic [5:0]         sats;
    logic [13:0]        pdop;
    logic [13:0]        hdop;
    logic signed [15:0] speed;
    reason_t            reason;
    logic               stuck;
    mon_state_t         state;
  } status_t;

  localparam logic [7:0] FAST_RUN_MAX = 8'd255;

  cfg_t        cfg;
  logic        mon_on;
  logic        have_fix;
  logic        tracking;
  logic [47:0] fix_utc;
  logic [31:0] fix_seen_ms;
  logic [31:0] motion_ms;
  logic [7:0]  fast_run;
  status_t     status;
  status_t     expected_status[$];

  initial errors = 0;

  task automatic set_verdict(input mon_state_t s, input logic stuck, input reason_t r);
    status.state  = s;
    status.stuck  = stuck;
    status.reason = r;
  endtask

  task automatic drop_track();
    tracking  = 1'b0;
    fast_run  = '0;
    motion_ms = '0;
  endtask

  task automatic reset_detector();
    cfg.min_fix_grade     = RST_MIN_FIX_GRADE;
    cfg.min_satellites    = RST_MIN_SATELLITES;
    cfg.max_hdop_centi    = RST_MAX_HDOP_CENTI;
    cfg.max_pdop_centi    = RST_MAX_PDOP_CENTI;
    cfg.moving_speed_mm_s = RST_MOVING_SPEED_MM_S;
    cfg.confirm_samples   = RST_CONFIRM_SAMPLES;
    cfg.stuck_timeout_ms  = RST_STUCK_TIMEOUT_MS;
    cfg.stale_timeout_ms  = RST_STALE_TIMEOUT_MS;
    mon_on      = 1'b1;
    have_fix    = 1'b0;
    fix_utc     = '0;
    fix_seen_ms = '0;
    drop_track();
    status = '0;
    set_verdict(ST_INITIAL, 1'b0, RS_NONE);
    expected_status.delete();
  endtask

  task automatic take_sample(input fix_req_t r);
    logic moving;
    if (!mon_on) begin
      set_verdict(ST_DISABLED, 1'b0, RS_DISABLED);
      return;
    end
    status.speed = r.speed;
    status.hdop  = r.hdop;
    status.pdop  = r.pdop;
    status.sats  = r.sats;
    status.fixq  = r.fixq;
    if (!r.valid || r.utc == '0 || r.lat == '0 || r.lon == '0 ||
        r.fixq < cfg.min_fix_grade) begin
      drop_track();
      set_verdict(ST_WAITING, 1'b0, RS_INVALID);
      return;
    end
    // same timestamp again: only goes stale once the timeout has passed
    if (have_fix && r.utc == fix_utc) begin
      if (32'(r.now - fix_seen_ms) > cfg.stale_timeout_ms) begin
        drop_track();
        set_verdict(ST_WAITING, 1'b0, RS_STALE);
      end
      return;
    end
    if (r.speed[15]) begin
      drop_track();
      set_verdict(ST_WAITING, 1'b0, RS_BAD_SPEED);
      return;
    end
    have_fix    = 1'b1;
    fix_utc     = r.utc;
    fix_seen_ms = r.now;
    status.utc  = r.utc;
    if (r.sats < cfg.min_satellites || r.hdop == '0 || r.hdop > cfg.max_hdop_centi ||
        (r.pdop != '0 && r.pdop > cfg.max_pdop_centi)) begin
      drop_track();
      set_verdict(ST_POOR, 1'b0, RS_POOR);
      return;
    end
    moving = r.speed[14:0] >= cfg.moving_speed_mm_s;
    if (!tracking) begin
      tracking  = 1'b1;
      motion_ms = r.now;
      fast_run  = moving ? 8'd1 : 8'd0;
      set_verdict(ST_MONITORING, 1'b0, RS_MONITORING);
      return;
    end
    if (moving) begin
      if (fast_run != FAST_RUN_MAX) fast_run++;
    end else begin
      fast_run = '0;
    end
    if (fast_run >= cfg.confirm_samples) begin
      motion_ms = r.now;
      set_verdict(ST_MONITORING, 1'b0, RS_MOVING);
      return;
    end
    if (32'(r.now - motion_ms) >= cfg.stuck_timeout_ms) begin
      set_verdict(ST_STUCK, 1'b1, RS_TIMEOUT);
      return;
    end
    set_verdict(ST_MONITORING, 1'b0, RS_MONITORING);
  endtask

  task automatic advance_detector(input logic [1:0] kind, input fix_req_t r);
    case (kind)
      KIND_SAMPLE: take_sample(r);
      KIND_CLEAR: begin
        if (status.state == ST_STUCK) begin
          motion_ms     = r.now;
          status.state  = ST_MONITORING;
          status.reason = RS_CLEARED;
        end
        status.stuck = 1'b0;
      end
      KIND_ENABLE: begin
        mon_on = r.enable;
        if (!r.enable) begin
          set_verdict(ST_DISABLED, 1'b0, RS_DISABLED);
          drop_track();
        end
      end
      default: ;
    endcase
    expected_status.push_back(status);
  endtask

  task automatic apply_write();
    case (cfg_index)
      CFG_MIN_FIX_GRADE:     cfg.min_fix_grade     = cfg_data[3:0];
      CFG_MIN_SATELLITES:    cfg.min_satellites    = cfg_data[5:0];
      CFG_MAX_HDOP_CENTI:    cfg.max_hdop_centi    = cfg_data[13:0];
      CFG_MAX_PDOP_CENTI:    cfg.max_pdop_centi    = cfg_data[13:0];
      CFG_MOVING_SPEED_MM_S: cfg.moving_speed_mm_s = cfg_data[14:0];
      CFG_CONFIRM_SAMPLES:   cfg.confirm_samples   = cfg_data[7:0];
      CFG_STUCK_TIMEOUT_MS:  cfg.stuck_timeout_ms  = cfg_data;
      CFG_STALE_TIMEOUT_MS:  cfg.stale_timeout_ms  = cfg_data;
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  task automatic check_result(input status_t got);
    status_t want;
    if (expected_status.size() == 0) begin
      $error("result %0h with no request waiting", got);
      errors++;
      return;
    end
    want = expected_status.pop_front();
    check_field("monitor_state", want.state, got.state);
    check_field("stuck_flag", want.stuck, got.stuck);
    check_field("reason_code", want.reason, got.reason);
    check_field("last_speed_mm_s", want.speed, got.speed);
    check_field("last_hdop_centi", want.hdop, got.hdop);
    check_field("last_pdop_centi", want.pdop, got.pdop);
    check_field("last_satellites", want.sats, got.sats);
    check_field("last_fix_grade", want.fixq, got.fixq);
    check_field("last_accepted_utc_ms", want.utc, got.utc);
    check_field("tdata_pad", want.pad, got.pad);
  endtask

  // results first: a result never belongs to a request taken at the same edge
  always @(posedge clk) begin
    if (rst) begin
      reset_detector();
    end else begin
      if (m_tvalid && m_tready) check_result(status_t'(m_tdata));
      if (cfg_we) apply_write();
      if (s_tvalid && s_tready) advance_detector(s_tuser, fix_req_t'(s_tdata));
    end
    pending = expected_status.size();
  end

endmodule

>>> tb/tb_gps_stuck_detector.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gps_stuck_detector: stimulus for the GPS stuck detector
// Directed fixes through every status path, then random fix streams under
// several register settings with random stalls on both sides of the block.
// ----------------------------------------------------------------------------
module tb_gps_stuck_detector;
  import gsd_pkg::*;

  typedef struct packed {
    logic               pad;
    logic               enable;
    logic [13:0]        pdop;
    logic [13:0]        hdop;
    logic signed [15:0] speed;
    logic [5:0]         sats;
    logic [3:0]         fixq;
    logic signed [31:0] lon;
    logic signed [30:0] lat;
    logic [47:0]        utc;
    logic               valid;
    logic [31:0]        now;
  } fix_req_t;

  localparam logic [1:0] KIND_UNUSED      = 2'd3;
  localparam int         QUIET_LIMIT      = 3000;
  localparam int         LONG_HOLD_CYCLES = 48;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic [1:0]            s_tuser   = '0;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  int                    errors;
  int                    pending;
  int                    quiet     = 0;
  bit                    idle_on   = 1'b1;
  bit                    long_hold = 1'b0;

  cfg_t        cur_cfg;
  logic [31:0] clock_ms;
  logic [47:0] gps_utc;
  int          motion_pct;

  gps_stuck_detector dut (
    .clk       (clk),
    .rst       (rst),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gsd_status_checker chk (
    .clk       (clk),
    .rst       (rst),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("tb_gps_stuck_detector: done, errors");
        $finish;
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
        m_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic offer(input logic [1:0] kind, input fix_req_t r);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_tuser  <= kind;
    s_tdata  <= r;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  // hold requests until every expected result is back
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_config(input cfg_t c);
    cur_cfg = c;
    for (int k = 0; k < 8; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= k[CFG_IDX_W-1:0];
      case (cfg_idx_t'(k))
        CFG_MIN_FIX_GRADE:     cfg_data <= 32'(c.min_fix_grade);
        CFG_MIN_SATELLITES:    cfg_data <= 32'(c.min_satellites);
        CFG_MAX_HDOP_CENTI:    cfg_data <= 32'(c.max_hdop_centi);
        CFG_MAX_PDOP_CENTI:    cfg_data <= 32'(c.max_pdop_centi);
        CFG_MOVING_SPEED_MM_S: cfg_data <= 32'(c.moving_speed_mm_s);
        CFG_CONFIRM_SAMPLES:   cfg_data <= 32'(c.confirm_samples);
        CFG_STUCK_TIMEOUT_MS:  cfg_data <= c.stuck_timeout_ms;
        default:               cfg_data <= c.stale_timeout_ms;
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.min_fix_grade     = 4'($urandom_range(0, 3));
    c.min_satellites    = 6'($urandom_range(0, 8));
    c.max_hdop_centi    = 14'($urandom_range(100, 9999));
    c.max_pdop_centi    = 14'($urandom_range(100, 9999));
    c.moving_speed_mm_s = 15'($urandom_range(0, 300));
    c.confirm_samples   = 8'($urandom_range(0, 6));
    c.stuck_timeout_ms  = $urandom_range(0, 20000);
    c.stale_timeout_ms  = $urandom_range(0, 4000);
    return c;
  endfunction

  task automatic tick(input int unsigned step);
    clock_ms += step;
    gps_utc  += 48'(step);
  endtask

  // well-formed fix under the current settings, speed biased by motion_pct
  function automatic fix_req_t good_fix();
    fix_req_t r;
    int       thr;
    r       = '0;
    r.now   = clock_ms;
    r.valid = 1'b1;
    r.utc   = gps_utc;
    r.lat   = 31'($urandom_range(1, 900000000));
    if ($urandom_range(0, 1)) r.lat = -r.lat;
    r.lon   = $urandom_range(1, 1800000000);
    if ($urandom_range(0, 1)) r.lon = -r.lon;
    r.fixq  = 4'($urandom_range(cur_cfg.min_fix_grade, 15));
    r.sats  = 6'($urandom_range(cur_cfg.min_satellites, 63));
    r.hdop  = 14'($urandom_range(1, cur_cfg.max_hdop_centi));
    r.pdop  = ($urandom_range(0, 2) == 0) ? 14'd0 : 14'($urandom_range(0, cur_cfg.max_pdop_centi));
    thr     = int'(cur_cfg.moving_speed_mm_s);
    if ($urandom_range(0, 99) < motion_pct)
      r.speed = ($urandom_range(0, 3) == 0) ? 16'(thr) : 16'($urandom_range(thr, 32767));
    else if (thr == 0)
      r.speed = '0;
    else
      r.speed = ($urandom_range(0, 3) == 0) ? 16'(thr - 1) : 16'($urandom_range(0, thr - 1));
    r.enable = 1'($urandom_range(0, 1));
    return r;
  endfunction

  task automatic break_fix(inout fix_req_t r);
    logic [223:0] bits;
    case ($urandom_range(0, 7))
      0: r.valid = 1'b0;
      1: r.utc = '0;
      2: r.lat = '0;
      3: r.lon = '0;
      4: begin
        if (cur_cfg.min_fix_grade != 0)
          r.fixq = 4'($urandom_range(0, cur_cfg.min_fix_grade - 1));
        else
          r.valid = 1'b0;
      end
      5: r.speed = $urandom_range(0, 1) ? -16'sd1 : 16'(16'h8000 | 16'($urandom));
      6: begin
        case ($urandom_range(0, 3))
          0: begin
            if (cur_cfg.min_satellites != 0)
              r.sats = 6'($urandom_range(0, cur_cfg.min_satellites - 1));
            else
              r.hdop = '0;
          end
          1: r.hdop = '0;
          2: begin
            if (cur_cfg.max_hdop_centi != 14'h3FFF)
              r.hdop = 14'($urandom_range(cur_cfg.max_hdop_centi + 1, 16383));
            else
              r.hdop = '0;
          end
          default: begin
            if (cur_cfg.max_pdop_centi != 14'h3FFF)
              r.pdop = 14'($urandom_range(cur_cfg.max_pdop_centi + 1, 16383));
            else
              r.hdop = '0;
          end
        endcase
      end
      default: begin
        bits  = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        r     = bits[IN_DATA_W-1:0];
        r.pad = 1'b0;
      end
    endcase
  endtask

  task automatic random_item(output logic [1:0] kind);
    fix_req_t    r;
    int unsigned pick;
    int unsigned roll;
    if ($urandom_range(0, 19) == 0) motion_pct = $urandom_range(0, 100);
    pick = $urandom_range(0, 99);
    roll = $urandom_range(0, 99);
    if (roll < 75)      clock_ms += $urandom_range(0, 1500);
    else if (roll < 95) clock_ms += $urandom_range(0, 40000);
    else                clock_ms += $urandom;
    if (pick < 6) begin
      kind = KIND_CLEAR;
      r    = good_fix();
    end else if (pick < 11) begin
      kind     = KIND_ENABLE;
      r        = good_fix();
      r.enable = ($urandom_range(0, 3) != 0);
    end else if (pick < 13) begin
      kind = KIND_UNUSED;
      r    = good_fix();
    end else begin
      kind = KIND_SAMPLE;
      roll = $urandom_range(0, 99);
      // repeat the timestamp now and then to exercise staleness
      if (roll >= 10) gps_utc += 48'($urandom_range(1, 1500));
      r = good_fix();
      if (roll >= 85) break_fix(r);
    end
    offer(kind, r);
  endtask

  task automatic run_random(input int count);
    logic [1:0] kind;
    int         done_items;
    done_items = 0;
    while (done_items < count) begin
      random_item(kind);
      if (kind != KIND_UNUSED) done_items++;
    end
  endtask

  function automatic fix_req_t base_fix();
    fix_req_t r;
    r       = '0;
    r.now   = clock_ms;
    r.valid = 1'b1;
    r.utc   = gps_utc;
    r.lat   = 31'sd473977000;
    r.lon   = 32'sd85456000;
    r.fixq  = 4'd1;
    r.sats  = 6'd4;
    r.hdop  = 14'd500;
    r.pdop  = 14'd600;
    r.speed = 16'sd50;
    return r;
  endfunction

  // reset settings: every status path, at the accept boundaries
  task automatic directed_checks();
    fix_req_t r;
    clock_ms = 32'd1000;
    gps_utc  = 48'd1700000000000;
    r = base_fix(); r.valid = 1'b0;           offer(KIND_SAMPLE, r);
    tick(1000); r = base_fix(); r.utc = '0;   offer(KIND_SAMPLE, r);
    tick(1000); r = base_fix(); r.lat = '0;   offer(KIND_SAMPLE, r);
    tick(1000); r = base_fix(); r.lon = '0;   offer(KIND_SAMPLE, r);
    tick(1000); r = base_fix(); r.fixq = '0;  offer(KIND_SAMPLE, r);
    tick(1000); r = base_fix(); r.speed = -16'sd1; offer(KIND_SAMPLE, r);
    tick(1000); r = base_fix(); r.sats = 6'd3;     offer(KIND_SAMPLE, r);
    tick(1000); r = base_fix(); r.hdop = '0;       offer(KIND_SAMPLE, r);
    tick(1000); r = base_fix(); r.hdop = 14'd501;  offer(KIND_SAMPLE, r);
    tick(1000); r = base_fix(); r.pdop = 14'd601;  offer(KIND_SAMPLE, r);
    // first accepted fix starts tracking
    tick(1000); r = base_fix(); offer(KIND_SAMPLE, r);
    // same timestamp: fresh within the stale time, then stale
    clock_ms += 2000; r = base_fix(); r.hdop = 14'd77; offer(KIND_SAMPLE, r);
    clock_ms += 2000; r = base_fix(); offer(KIND_SAMPLE, r);
    tick(1000);  r = base_fix(); r.speed = 16'sd49; offer(KIND_SAMPLE, r);
    tick(31000); r = base_fix(); r.speed = 16'sd49; offer(KIND_SAMPLE, r);
    tick(100); offer(KIND_CLEAR, base_fix());
    tick(100); offer(KIND_CLEAR, base_fix());
    repeat (3) begin
      tick(500);
      r = base_fix(); r.speed = 16'sd32767; r.lat = 31'sd900000000; r.lon = -32'sd1800000000;
      offer(KIND_SAMPLE, r);
    end
    tick(500);
    r = base_fix(); r.lat = -31'sd900000000; r.lon = 32'sd1800000000; r.fixq = 4'd15;
    offer(KIND_SAMPLE, r);
    offer(KIND_UNUSED, base_fix());
    r = base_fix(); r.enable = 1'b0; offer(KIND_ENABLE, r);
    tick(500); r = base_fix(); r.sats = 6'd63; offer(KIND_SAMPLE, r);
    r = base_fix(); r.enable = 1'b1; offer(KIND_ENABLE, r);
    tick(500); r = base_fix(); offer(KIND_SAMPLE, r);
  endtask

  initial begin
    cfg_t c;
    fix_req_t r;
    motion_pct = 50;
    cur_cfg.min_fix_grade     = RST_MIN_FIX_GRADE;
    cur_cfg.min_satellites    = RST_MIN_SATELLITES;
    cur_cfg.max_hdop_centi    = RST_MAX_HDOP_CENTI;
    cur_cfg.max_pdop_centi    = RST_MAX_PDOP_CENTI;
    cur_cfg.moving_speed_mm_s = RST_MOVING_SPEED_MM_S;
    cur_cfg.confirm_samples   = RST_CONFIRM_SAMPLES;
    cur_cfg.stuck_timeout_ms  = RST_STUCK_TIMEOUT_MS;
    cur_cfg.stale_timeout_ms  = RST_STALE_TIMEOUT_MS;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    directed_checks();
    settle();

    c = '{4'd2, 6'd5, 14'd300, 14'd400, 15'd100, 8'd2, 32'd5000, 32'd1500};
    write_config(c);
    // back-to-back requests against a held result side fill the queue
    idle_on   = 1'b0;
    long_hold = 1'b1;
    run_random(16);
    idle_on = 1'b1;
    run_random(184);
    settle();

    // lowest settings: zero confirm count, zero timeouts, pdop must be absent
    c = '{4'd0, 6'd0, 14'd9999, 14'd0, 15'd0, 8'd0, 32'd0, 32'd0};
    write_config(c);
    run_random(180);
    settle();

    // highest settings, with a moving run long enough to saturate the counter
    c = '{4'd15, 6'd63, 14'd9999, 14'd9999, 15'd32767, 8'd255,
          32'hFFFF_FFFF, 32'hFFFF_FFFF};
    write_config(c);
    r = good_fix(); r.enable = 1'b1; offer(KIND_ENABLE, r);
    repeat (270) begin
      tick($urandom_range(1, 1500));
      r = good_fix();
      r.speed = 16'sd32767;
      offer(KIND_SAMPLE, r);
    end
    run_random(100);
    settle();

    // no hdop can pass
    c = random_cfg();
    c.max_hdop_centi = '0;
    write_config(c);
    run_random(60);
    settle();

    repeat (2) begin
      write_config(random_cfg());
      run_random(200);
      settle();
    end

    idle_on = 1'b0;
    write_config(random_cfg());
    run_random(200);
    settle();
    repeat (8) @(posedge clk);

    if (errors == 0)
      $display("tb_gps_stuck_detector: done, clean");
    else
      $display("tb_gps_stuck_detector: done, errors");
    $finish;
  end

endmodule

>>> sim.f
src/gsd_pkg.sv
src/gsd_front.sv
src/gsd_queue.sv
src/gsd_back.sv
src/gps_stuck_detector.sv
tb/gsd_status_checker.sv
tb/tb_gps_stuck_detector.sv
